FILE: rtl/core/esdr_pkg.sv
// ----------------------------------------------------------------------------
// Edge stream distance relaxer package
// Shared widths, constants, mode codes and controller states.
// ----------------------------------------------------------------------------
package esdr_pkg;

	localparam int VERTEX_W = 16;
	localparam int DIST_W = 31;
	localparam int MODE_W = 2;

	localparam int DEF_VERTEX_COUNT = 65536;
	localparam int ADDR_SPACE = 65536;

	localparam logic [DIST_W-1:0] INF_DIST = 31'd2000000000;

	localparam logic [MODE_W-1:0] MODE_RELAX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_READY,
		ST_APPLY
	} ctrl_state_t;

endpackage

FILE: rtl/core/edge_stream_distance_relaxer.sv
// ----------------------------------------------------------------------------
// Edge stream distance relaxer
// Keeps a distance label per vertex in a block memory and relaxes weighted
// edges one word at a time, answers label queries and restarts the labels.
// ----------------------------------------------------------------------------
//
// Channel   Handshake              Word
// input     start, busy            mode, from_vertex, to_vertex, edge_weight,
//                                  query_vertex
// result    done (one-cycle strobe) distance, was_updated, is_reached
// config    cfg_valid, cfg_ready   cfg_data (source vertex)
//
// Edge and query words pass through a registered label read and then the
// apply state, which adds, compares and writes the label memory.
// A restart word sweeps the label memory one entry per cycle and gives its
// result when the sweep reaches the last entry.
// After reset the same sweep runs with busy high and gives no result;
// configuration writes are taken only while busy is low.
// The receiver cannot stall; done is high for exactly one cycle per word.
module edge_stream_distance_relaxer #(
	parameter int VERTEX_COUNT = esdr_pkg::DEF_VERTEX_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [esdr_pkg::MODE_W-1:0]   mode,
	input  logic [esdr_pkg::VERTEX_W-1:0] from_vertex,
	input  logic [esdr_pkg::VERTEX_W-1:0] to_vertex,
	input  logic [esdr_pkg::DIST_W-1:0]   edge_weight,
	input  logic [esdr_pkg::VERTEX_W-1:0] query_vertex,
	output logic                          done,
	output logic [esdr_pkg::DIST_W-1:0]   distance,
	output logic                          was_updated,
	output logic                          is_reached,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [esdr_pkg::VERTEX_W-1:0] cfg_data
);
	import esdr_pkg::*;

	localparam int MEM_DEPTH = (VERTEX_COUNT > ADDR_SPACE) ? ADDR_SPACE : VERTEX_COUNT;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [VERTEX_W:0] LIMIT = (VERTEX_W+1)'(MEM_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

	ctrl_state_t state_q, state_d;

	logic [DIST_W-1:0] label_mem [MEM_DEPTH];

	logic [VERTEX_W-1:0] source_vertex_q;
	logic [AW-1:0] clr_idx_q;
	logic report_q;

	logic accept;
	logic is_restart;
	logic is_edge;
	logic [VERTEX_W-1:0] rd_a_vertex;
	logic rd_a_ok;
	logic rd_b_ok;
	logic src_ok;
	logic clr_last;

	logic is_edge_s1;
	logic a_ok_s1;
	logic b_ok_s1;
	logic [AW-1:0] b_addr_s1;
	logic [DIST_W-1:0] weight_s1;
	logic [DIST_W-1:0] rd_a_s1;
	logic [DIST_W-1:0] rd_b_s1;

	logic [DIST_W-1:0] a_lbl;
	logic [DIST_W-1:0] b_lbl;
	logic [DIST_W:0] sum;
	logic [DIST_W-1:0] cand;
	logic lower;
	logic [DIST_W-1:0] apply_dist;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [DIST_W-1:0] wr_data;

	assign accept = start && !busy;
	assign is_restart = (mode == MODE_RESTART);
	assign is_edge = (mode == MODE_RELAX);
	assign rd_a_vertex = is_edge ? from_vertex : query_vertex;
	assign rd_a_ok = ({1'b0, rd_a_vertex} < LIMIT);
	assign rd_b_ok = ({1'b0, to_vertex} < LIMIT);
	assign src_ok = ({1'b0, source_vertex_q} < LIMIT);
	assign clr_last = (clr_idx_q == LAST_ADDR);

	assign a_lbl = a_ok_s1 ? rd_a_s1 : INF_DIST;
	assign b_lbl = b_ok_s1 ? rd_b_s1 : INF_DIST;
	assign sum = {1'b0, a_lbl} + {1'b0, weight_s1};
	assign cand = (sum >= {1'b0, INF_DIST}) ? INF_DIST : sum[DIST_W-1:0];
	assign lower = is_edge_s1 && b_ok_s1 && (b_lbl > cand);
	assign apply_dist = is_edge_s1 ? (lower ? cand : b_lbl) : a_lbl;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_READY;
				end
			end
			ST_READY: begin
				if (start) begin
					state_d = is_restart ? ST_CLEAR : ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_READY;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		wr_en = 1'b0;
		wr_addr = clr_idx_q;
		wr_data = INF_DIST;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = (src_ok && (source_vertex_q[AW-1:0] == clr_idx_q)) ?
					'0 : INF_DIST;
			end
			ST_READY: begin
				busy = 1'b0;
			end
			ST_APPLY: begin
				wr_en = lower;
				wr_addr = b_addr_s1;
				wr_data = cand;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			report_q <= 1'b0;
			source_vertex_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				source_vertex_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				if (clr_last) begin
					clr_idx_q <= '0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end
			if (accept && is_restart) begin
				report_q <= 1'b1;
			end else if (state_q == ST_CLEAR && clr_last) begin
				report_q <= 1'b0;
			end
			if (state_q == ST_APPLY) begin
				done <= 1'b1;
			end else if (state_q == ST_CLEAR && clr_last) begin
				done <= report_q;
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_edge_s1 <= is_edge;
			a_ok_s1 <= rd_a_ok;
			b_ok_s1 <= rd_b_ok;
			b_addr_s1 <= to_vertex[AW-1:0];
			weight_s1 <= edge_weight;
		end
		if (state_q == ST_APPLY) begin
			distance <= apply_dist;
			was_updated <= lower;
			is_reached <= (apply_dist < INF_DIST);
		end else if (state_q == ST_CLEAR && clr_last) begin
			distance <= src_ok ? '0 : INF_DIST;
			was_updated <= 1'b0;
			is_reached <= src_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			label_mem[wr_addr] <= wr_data;
		end
		rd_a_s1 <= label_mem[rd_a_vertex[AW-1:0]];
		rd_b_s1 <= label_mem[to_vertex[AW-1:0]];
	end

`ifndef SYNTHESIS
	a_apply_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |=> done)
		else $error("apply cycle gave no result");

	a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !done)
		else $error("result during label sweep");

	a_update_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_updated) |-> is_reached)
		else $error("label lowered to unreached distance");

	a_edge_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_restart) |=> (state_q == ST_APPLY))
		else $error("accepted word did not enter apply");

	a_restart_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_restart) |=> (state_q == ST_CLEAR && clr_idx_q == '0))
		else $error("restart did not start sweep at entry zero");
`endif

endmodule

FILE: verif/tb_edge_stream_distance_relaxer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge stream distance relaxer testbench
// Sends directed and random edge, query and restart words through the
// start/busy port and rewrites the source vertex register between segments.
// A label model of its own predicts every result, and each done strobe is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_edge_stream_distance_relaxer;
	import esdr_pkg::*;

	localparam int VCOUNT = DEF_VERTEX_COUNT;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [DIST_W-1:0] MAX_WEIGHT = '1;
	localparam int STALL_LIMIT = 4 * ADDR_SPACE;
	localparam int POOL_SIZE = 24;
	localparam int SEGMENT_WORDS = 170;

	typedef enum logic [1:0] {
		ENTRY_WORD,
		ENTRY_CFG,
		ENTRY_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [MODE_W-1:0] mode;
		logic [VERTEX_W-1:0] from_v;
		logic [VERTEX_W-1:0] to_v;
		logic [DIST_W-1:0] weight;
		logic [VERTEX_W-1:0] query_v;
		logic [VERTEX_W-1:0] cfg_value;
		int unsigned idle_pct;
	} entry_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic was_updated;
		logic is_reached;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [MODE_W-1:0] mode = '0;
	logic [VERTEX_W-1:0] from_vertex = '0;
	logic [VERTEX_W-1:0] to_vertex = '0;
	logic [DIST_W-1:0] edge_weight = '0;
	logic [VERTEX_W-1:0] query_vertex = '0;
	logic cfg_valid = 1'b0;
	logic [VERTEX_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic [DIST_W-1:0] distance;
	logic was_updated;
	logic is_reached;
	logic cfg_ready;

	logic word_taken = 1'b0;
	logic cfg_taken = 1'b0;
	int error_count = 0;
	int quiet_cycles = 0;

	entry_t pending_words[$];
	result_t pending_results[$];

	logic [DIST_W-1:0] label_store [ADDR_SPACE];
	logic [VERTEX_W-1:0] source_reg = '0;
	logic [VERTEX_W-1:0] vertex_pool [POOL_SIZE];

	edge_stream_distance_relaxer #(
		.VERTEX_COUNT(VCOUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.from_vertex(from_vertex),
		.to_vertex(to_vertex),
		.edge_weight(edge_weight),
		.query_vertex(query_vertex),
		.done(done),
		.distance(distance),
		.was_updated(was_updated),
		.is_reached(is_reached),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [DIST_W-1:0] read_label(input logic [VERTEX_W-1:0] v);
		return (v < VCOUNT) ? label_store[v] : INF_DIST;
	endfunction

	function automatic void clear_labels();
		foreach (label_store[i]) label_store[i] = INF_DIST;
		if (source_reg < VCOUNT) label_store[source_reg] = '0;
	endfunction

	function automatic result_t relax_word(input logic [MODE_W-1:0] m,
			input logic [VERTEX_W-1:0] tail, input logic [VERTEX_W-1:0] head,
			input logic [DIST_W-1:0] w, input logic [VERTEX_W-1:0] qv);
		logic [DIST_W+1:0] sum;
		logic [DIST_W-1:0] cand;
		result_t r;
		r.was_updated = 1'b0;
		case (m)
			MODE_RELAX: begin
				sum = {2'b00, read_label(tail)} + {2'b00, w};
				cand = (sum >= INF_DIST) ? INF_DIST : sum[DIST_W-1:0];
				r.distance = read_label(head);
				if (head < VCOUNT && r.distance > cand) begin
					label_store[head] = cand;
					r.distance = cand;
					r.was_updated = 1'b1;
				end
			end
			MODE_RESTART: begin
				clear_labels();
				r.distance = read_label(source_reg);
			end
			default: begin
				r.distance = read_label(qv);
			end
		endcase
		r.is_reached = r.distance < INF_DIST;
		return r;
	endfunction

	function automatic void add_word(input logic [MODE_W-1:0] m,
			input logic [VERTEX_W-1:0] tail, input logic [VERTEX_W-1:0] head,
			input logic [DIST_W-1:0] w, input logic [VERTEX_W-1:0] qv,
			input int unsigned pct);
		entry_t e;
		e.kind = ENTRY_WORD;
		e.mode = m;
		e.from_v = tail;
		e.to_v = head;
		e.weight = w;
		e.query_v = qv;
		e.cfg_value = '0;
		e.idle_pct = pct;
		pending_words.push_back(e);
	endfunction

	function automatic void add_marker(input entry_kind_t k, input logic [VERTEX_W-1:0] value);
		entry_t e;
		e.kind = k;
		e.mode = MODE_QUERY;
		e.from_v = '0;
		e.to_v = '0;
		e.weight = '0;
		e.query_v = '0;
		e.cfg_value = value;
		e.idle_pct = 0;
		pending_words.push_back(e);
	endfunction

	function automatic logic [VERTEX_W-1:0] rand_vertex();
		return VERTEX_W'($urandom_range(65535));
	endfunction

	function automatic logic [DIST_W-1:0] rand_weight();
		return DIST_W'($urandom());
	endfunction

	function automatic logic [DIST_W-1:0] pick_weight();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return DIST_W'($urandom_range(1000));
			5: return DIST_W'($urandom_range(100000));
			6: return rand_weight();
			7: return INF_DIST - DIST_W'($urandom_range(5));
			8: return $urandom_range(1) ? MAX_WEIGHT : INF_DIST;
			default: return '0;
		endcase
	endfunction

	function automatic logic [VERTEX_W-1:0] pool_vertex();
		return vertex_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	always @(negedge clk) begin : driver
		entry_t head;
		if (arst_n) begin
			if (cfg_valid) begin
				if (cfg_taken) cfg_valid <= 1'b0;
			end else if (!start || word_taken) begin
				if (pending_words.size() == 0) begin
					start <= 1'b0;
				end else if (pending_words[0].kind != ENTRY_WORD) begin
					start <= 1'b0;
					if (!start && pending_results.size() == 0) begin
						head = pending_words.pop_front();
						if (head.kind == ENTRY_CFG) begin
							cfg_data <= head.cfg_value;
							cfg_valid <= 1'b1;
						end
					end
				end else if ($urandom_range(99) < pending_words[0].idle_pct) begin
					start <= 1'b0;
				end else begin
					head = pending_words.pop_front();
					mode <= head.mode;
					from_vertex <= head.from_v;
					to_vertex <= head.to_v;
					edge_weight <= head.weight;
					query_vertex <= head.query_v;
					start <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t got;
		result_t want;
		if (arst_n) begin
			word_taken <= start && !busy;
			cfg_taken <= cfg_valid && cfg_ready;
			if (done) begin
				got = '{distance, was_updated, is_reached};
				if (pending_results.size() == 0) begin
					$error("Result word with no prediction waiting: distance %0d", distance);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.distance !== want.distance) begin
						$error("distance: expected %0d, actual %0d", want.distance, got.distance);
						error_count++;
					end
					if (got.was_updated !== want.was_updated) begin
						$error("was_updated: expected %0d, actual %0d",
							want.was_updated, got.was_updated);
						error_count++;
					end
					if (got.is_reached !== want.is_reached) begin
						$error("is_reached: expected %0d, actual %0d",
							want.is_reached, got.is_reached);
						error_count++;
					end
				end
			end
			if (start && !busy)
				pending_results.push_back(relax_word(mode, from_vertex, to_vertex,
					edge_weight, query_vertex));
			if (cfg_valid && cfg_ready) source_reg = cfg_data;
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pct;
		int segment;
		int pick;
		logic [VERTEX_W-1:0] src;
		clear_labels();

		pct = 30;
		add_word(MODE_QUERY, 16'hFFFF, 16'hFFFF, MAX_WEIGHT, 16'd0, pct);
		add_word(MODE_QUERY, 16'd0, 16'd0, '0, 16'hFFFF, pct);
		add_word(MODE_RELAX, 16'd0, 16'd1, 31'd5, 16'hFFFF, pct);
		add_word(MODE_RELAX, 16'd1, 16'd2, '0, 16'd0, pct);
		add_word(MODE_RELAX, 16'd0, 16'd1, 31'd10, 16'd0, pct);
		add_word(MODE_RELAX, 16'd1, 16'hFFFF, INF_DIST - 31'd6, 16'd0, pct);
		add_word(MODE_RELAX, 16'hFFFF, 16'd3, 31'd1, 16'd0, pct);
		add_word(MODE_RELAX, 16'd0, 16'd4, MAX_WEIGHT, 16'd0, pct);
		add_word(MODE_RELAX, 16'd0, 16'd5, INF_DIST, 16'd0, pct);
		add_word(MODE_RELAX, 16'd5, 16'd6, '0, 16'd0, pct);
		add_word(MODE_RELAX, 16'd2, 16'd2, '0, 16'd0, pct);
		add_word(MODE_SPARE, 16'hFFFF, 16'hFFFF, MAX_WEIGHT, 16'd1, pct);
		add_word(MODE_RELAX, 16'd1, 16'd0, '0, 16'd0, pct);
		add_word(MODE_RELAX, 16'd0, 16'd7, INF_DIST - 31'd1, 16'd0, pct);
		add_marker(ENTRY_CFG, 16'd100);
		add_word(MODE_QUERY, 16'd0, 16'd0, '0, 16'd100, pct);
		add_marker(ENTRY_CFG, 16'hFFFF);
		add_word(MODE_RESTART, 16'hFFFF, 16'hFFFF, MAX_WEIGHT, 16'hFFFF, pct);
		add_word(MODE_QUERY, 16'd0, 16'd0, '0, 16'hFFFF, pct);
		add_word(MODE_QUERY, 16'd0, 16'd0, '0, 16'd0, pct);
		add_word(MODE_QUERY, 16'd0, 16'd0, '0, 16'd1, pct);
		add_word(MODE_RELAX, 16'hFFFF, 16'd0, 31'd7, 16'd0, pct);

		for (int phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 30 : (phase == 1) ? 49 : 0;
			for (int s = 0; s < 3; s++) begin
				segment = phase * 3 + s;
				src = (segment % 3 == 0) ? 16'h0000 :
					(segment % 3 == 1) ? 16'hFFFF : rand_vertex();
				add_marker(ENTRY_CFG, src);
				vertex_pool[0] = src;
				vertex_pool[1] = 16'h0000;
				vertex_pool[2] = 16'hFFFF;
				for (int i = 3; i < POOL_SIZE; i++)
					vertex_pool[i] = rand_vertex();
				add_word(MODE_RESTART, rand_vertex(), rand_vertex(),
					rand_weight(), rand_vertex(), pct);
				for (int n = 0; n < SEGMENT_WORDS; n++) begin
					if (n == SEGMENT_WORDS / 2) add_marker(ENTRY_DRAIN, '0);
					pick = $urandom_range(99);
					if (pick < 70)
						add_word(MODE_RELAX, pool_vertex(), pool_vertex(), pick_weight(),
							rand_vertex(), pct);
					else if (pick < 80)
						add_word($urandom_range(4) == 0 ? MODE_SPARE : MODE_QUERY,
							rand_vertex(), rand_vertex(), rand_weight(),
							pool_vertex(), pct);
					else if (pick < 85)
						add_word(MODE_RELAX, rand_vertex(), rand_vertex(),
							rand_weight(), rand_vertex(), pct);
					else if (pick < 90)
						add_word(MODE_QUERY, rand_vertex(), rand_vertex(),
							rand_weight(), rand_vertex(), pct);
					else
						add_word(MODE_RELAX, src, pool_vertex(), pick_weight(),
							rand_vertex(), pct);
				end
			end
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (pending_words.size() != 0 || start || cfg_valid || pending_results.size() != 0);
		repeat (16) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: edge_stream_distance_relaxer.f
rtl/core/esdr_pkg.sv
rtl/core/edge_stream_distance_relaxer.sv
verif/tb_edge_stream_distance_relaxer.sv
